// ===== src/rsc_pkg.sv =====
// Shared constants, types and command structures for the reward statistics unit.
`default_nettype none
package rsc_pkg;

  localparam int unsigned REWARD_W   = 24;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned SQSUM_W    = 63;
  localparam int unsigned STD_W      = 23;
  localparam int unsigned WIN_W      = 8;
  localparam int unsigned THR_W      = 48;
  localparam int unsigned OUT_W      = 112;

  localparam int unsigned HIST_DEPTH = 128;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned WEFF_W     = $clog2(HIST_DEPTH + 1);
  localparam int unsigned SQV_W      = 2 * REWARD_W - 1;
  localparam int unsigned WSUM_W     = REWARD_W + WEFF_W;
  localparam int unsigned WSQ_W      = 2 * REWARD_W - 2 + WEFF_W;
  localparam int unsigned CMP_W      = THR_W + 2 * WEFF_W;

  localparam int unsigned MPLIER_W   = SUM_W;
  localparam int unsigned PROD_W     = 2 * SUM_W;
  localparam int unsigned ROOT_W     = PROD_W / 2;
  localparam int unsigned DIVD_W     = ROOT_W + 1;

  localparam int unsigned MULP_STEPS = COUNT_W;
  localparam int unsigned MULD_STEPS = MPLIER_W;
  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned DIV_STEPS  = DIVD_W;
  localparam int unsigned STEP_W     = 6;

  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
  localparam logic [REWARD_W-1:0] REWARD_MIN = {1'b1, {(REWARD_W-1){1'b0}}};
  localparam logic [REWARD_W-1:0] REWARD_MAX = {1'b0, {(REWARD_W-1){1'b1}}};

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE_THRESHOLD = 1'b1;
  localparam logic [WIN_W-1:0] WINDOW_RESET    = 8'd100;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 48'd167772;

  localparam logic MUL_SEL_P    = 1'b0;
  localparam logic MUL_SEL_D    = 1'b1;
  localparam logic DIV_SEL_STD  = 1'b0;
  localparam logic DIV_SEL_MEAN = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_MULP, S_MULD, S_SQRT, S_DIVS, S_DIVM, S_FIN
  } rsc_state_e;

  typedef struct packed {
    logic accept;
    logic upd;
    logic walk_start;
    logic mul_load;
    logic mul_sel;
    logic mul_step;
    logic save_p;
    logic sqrt_load;
    logic sqrt_step;
    logic div_load;
    logic div_sel;
    logic div_step;
    logic save_std;
    logic load_out;
  } rsc_cmd_t;

  typedef struct packed {
    logic walk_done;
  } rsc_stat_t;

endpackage
`default_nettype wire

// ===== src/rsc_window.sv =====
// History ring, window walk and convergence test.
`default_nettype none
module rsc_window (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [rsc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [rsc_pkg::THR_W-1:0]        cfg_wdata_i,
  input  wire rsc_pkg::rsc_cmd_t                cmd_i,
  input  wire logic signed [rsc_pkg::REWARD_W-1:0] reward_i,
  input  wire logic [rsc_pkg::COUNT_W-1:0]      count_i,
  output rsc_pkg::rsc_stat_t                    stat_o,
  output logic                                  converged_o
);

  logic [rsc_pkg::WIN_W-1:0]  win_len_q;
  logic [rsc_pkg::THR_W-1:0]  thr_q;
  logic signed [rsc_pkg::REWARD_W-1:0] mem [rsc_pkg::HIST_DEPTH];
  logic [rsc_pkg::HIST_AW-1:0] wp_q;
  logic [rsc_pkg::HIST_AW-1:0] rd_addr;

  logic [rsc_pkg::WEFF_W-1:0] w_eff, weff_q, k_q;
  logic en_w, en_q;
  logic busy_q, issue_q, va_q, vb_q, done_q;
  logic [1:0] ph_q;

  logic signed [rsc_pkg::REWARD_W-1:0]   rd_q, rdb_q;
  logic signed [2*rsc_pkg::REWARD_W-1:0] rd_sq;
  logic [rsc_pkg::SQV_W-1:0]             sqv_q;
  logic signed [rsc_pkg::WSUM_W-1:0]     ws_q;
  logic [rsc_pkg::WSQ_W-1:0]             wsq_q;
  logic [rsc_pkg::WSUM_W-1:0]            sm;
  logic [rsc_pkg::CMP_W-1:0]             lhs_q, sq2_q, diff_q, rhs_q;
  logic [2*rsc_pkg::WEFF_W-1:0]          ww_q;
  logic                                  conv_q;
  logic                                  drained;

  // Oversized windows act as the full ring.
  assign w_eff = (int'(win_len_q) > rsc_pkg::HIST_DEPTH) ?
                 rsc_pkg::WEFF_W'(rsc_pkg::HIST_DEPTH) : rsc_pkg::WEFF_W'(win_len_q);
  assign en_w  = (w_eff != '0) && (count_i >= rsc_pkg::COUNT_W'(w_eff));
  assign rd_addr = wp_q - rsc_pkg::HIST_AW'(1) - k_q[rsc_pkg::HIST_AW-1:0];
  assign rd_sq   = rd_q * rd_q;
  assign sm      = ws_q[rsc_pkg::WSUM_W-1] ? rsc_pkg::WSUM_W'(-ws_q) : rsc_pkg::WSUM_W'(ws_q);
  assign drained = !issue_q && !va_q && !vb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= rsc_pkg::WINDOW_RESET;
      thr_q     <= rsc_pkg::THRESHOLD_RESET;
      wp_q      <= '0;
      busy_q    <= 1'b0;
      issue_q   <= 1'b0;
      va_q      <= 1'b0;
      vb_q      <= 1'b0;
      done_q    <= 1'b0;
      ph_q      <= '0;
      k_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rsc_pkg::CFG_WINDOW_LENGTH:      win_len_q <= cfg_wdata_i[rsc_pkg::WIN_W-1:0];
          rsc_pkg::CFG_VARIANCE_THRESHOLD: thr_q     <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.upd) wp_q <= wp_q + rsc_pkg::HIST_AW'(1);
      va_q <= issue_q;
      vb_q <= va_q;
      if (cmd_i.walk_start) begin
        busy_q  <= 1'b1;
        issue_q <= en_w;
        k_q     <= '0;
        done_q  <= 1'b0;
        ph_q    <= '0;
      end else if (busy_q) begin
        if (issue_q) begin
          k_q <= k_q + rsc_pkg::WEFF_W'(1);
          if (k_q == weff_q - rsc_pkg::WEFF_W'(1)) issue_q <= 1'b0;
        end
        if (drained) begin
          ph_q <= ph_q + 2'd1;
          if (ph_q == 2'd2) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) mem[wp_q] <= reward_i;
    rd_q  <= mem[rd_addr];
    rdb_q <= rd_q;
    sqv_q <= rsc_pkg::SQV_W'(rd_sq);
    if (cmd_i.walk_start) begin
      weff_q <= w_eff;
      en_q   <= en_w;
      ws_q   <= '0;
      wsq_q  <= '0;
    end else if (vb_q) begin
      ws_q  <= ws_q + rsc_pkg::WSUM_W'(rdb_q);
      wsq_q <= wsq_q + rsc_pkg::WSQ_W'(sqv_q);
    end
    if (busy_q && drained) begin
      unique case (ph_q)
        2'd0: begin
          lhs_q <= rsc_pkg::CMP_W'(weff_q * wsq_q);
          sq2_q <= rsc_pkg::CMP_W'(sm * sm);
          ww_q  <= weff_q * weff_q;
        end
        2'd1: begin
          diff_q <= (lhs_q >= sq2_q) ? lhs_q - sq2_q : '0;
          rhs_q  <= rsc_pkg::CMP_W'(thr_q * ww_q);
        end
        2'd2: conv_q <= en_q && (diff_q < rhs_q);
        default: ;
      endcase
    end
  end

  assign stat_o.walk_done = done_q;
  assign converged_o      = conv_q;

endmodule
`default_nettype wire

// ===== src/rsc_datapath.sv =====
// Running statistics registers, shift-add multiplier, square root and divider.
`default_nettype none
module rsc_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire rsc_pkg::rsc_cmd_t                cmd_i,
  input  wire logic [rsc_pkg::REWARD_W-1:0]     reward_in_i,
  input  wire logic                             converged_i,
  output logic signed [rsc_pkg::REWARD_W-1:0]   reward_o,
  output logic [rsc_pkg::COUNT_W-1:0]           count_o,
  output logic [rsc_pkg::OUT_W-1:0]             out_data_o
);

  logic [rsc_pkg::COUNT_W-1:0]         cnt_q;
  logic signed [rsc_pkg::REWARD_W-1:0] best_q, worst_q, rew_q;
  logic signed [rsc_pkg::SUM_W-1:0]    sum_q;
  logic [rsc_pkg::SQSUM_W-1:0]         sq_q;
  logic signed [2*rsc_pkg::REWARD_W-1:0] rsq;
  logic [rsc_pkg::SUM_W-1:0]           smag;

  logic [rsc_pkg::PROD_W-1:0]   mcand_q, acc_q, p_q, x_q, d_val;
  logic [rsc_pkg::MPLIER_W-1:0] mplier_q;
  logic [rsc_pkg::ROOT_W+1:0]   srem_q, srem_nx, trial;
  logic [rsc_pkg::ROOT_W-1:0]   root_q;
  logic [rsc_pkg::COUNT_W-1:0]  drem_q;
  logic [rsc_pkg::COUNT_W:0]    dtry, ddif;
  logic [rsc_pkg::DIVD_W-1:0]   quo_q;
  logic [rsc_pkg::STD_W-1:0]    std_q;
  logic [rsc_pkg::REWARD_W-1:0] mq, mean;
  logic [rsc_pkg::OUT_W-1:0]    out_q;

  assign rsq   = rew_q * rew_q;
  assign smag  = sum_q[rsc_pkg::SUM_W-1] ? rsc_pkg::SUM_W'(-sum_q) : rsc_pkg::SUM_W'(sum_q);
  assign d_val = (p_q >= acc_q) ? p_q - acc_q : '0;
  assign srem_nx = {srem_q[rsc_pkg::ROOT_W-1:0], x_q[rsc_pkg::PROD_W-1 -: 2]};
  assign trial   = {root_q, 2'b01};
  assign dtry    = {drem_q, quo_q[rsc_pkg::DIVD_W-1]};
  assign ddif    = dtry - {1'b0, cnt_q};
  assign mq      = quo_q[rsc_pkg::REWARD_W-1:0];
  assign mean    = sum_q[rsc_pkg::SUM_W-1] ? -mq : mq;

  // Statistics state; sums freeze once the count saturates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      best_q  <= rsc_pkg::REWARD_MIN;
      worst_q <= rsc_pkg::REWARD_MAX;
      sum_q   <= '0;
      sq_q    <= '0;
    end else if (cmd_i.upd) begin
      if (rew_q > best_q)  best_q  <= rew_q;
      if (rew_q < worst_q) worst_q <= rew_q;
      if (cnt_q != rsc_pkg::COUNT_MAX) begin
        cnt_q <= cnt_q + rsc_pkg::COUNT_W'(1);
        sum_q <= sum_q + rsc_pkg::SUM_W'(rew_q);
        sq_q  <= sq_q + rsc_pkg::SQSUM_W'(rsq[rsc_pkg::SQV_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) rew_q <= reward_in_i;

    if (cmd_i.save_p) p_q <= acc_q;
    if (cmd_i.mul_load) begin
      acc_q <= '0;
      if (cmd_i.mul_sel == rsc_pkg::MUL_SEL_P) begin
        mcand_q  <= rsc_pkg::PROD_W'(sq_q);
        mplier_q <= rsc_pkg::MPLIER_W'(cnt_q);
      end else begin
        mcand_q  <= rsc_pkg::PROD_W'(smag);
        mplier_q <= smag;
      end
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end

    if (cmd_i.sqrt_load) begin
      x_q    <= d_val;
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      x_q <= x_q << 2;
      if (srem_nx >= trial) begin
        srem_q <= srem_nx - trial;
        root_q <= {root_q[rsc_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        srem_q <= srem_nx;
        root_q <= {root_q[rsc_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    if (cmd_i.save_std) begin
      std_q <= (|quo_q[rsc_pkg::DIVD_W-1:rsc_pkg::STD_W]) ? '1 : quo_q[rsc_pkg::STD_W-1:0];
    end
    if (cmd_i.div_load) begin
      drem_q <= '0;
      quo_q  <= (cmd_i.div_sel == rsc_pkg::DIV_SEL_STD) ?
                rsc_pkg::DIVD_W'(root_q) : rsc_pkg::DIVD_W'(smag);
    end else if (cmd_i.div_step) begin
      if (!ddif[rsc_pkg::COUNT_W]) begin
        drem_q <= ddif[rsc_pkg::COUNT_W-1:0];
        quo_q  <= {quo_q[rsc_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        drem_q <= dtry[rsc_pkg::COUNT_W-1:0];
        quo_q  <= {quo_q[rsc_pkg::DIVD_W-2:0], 1'b0};
      end
    end

    if (cmd_i.load_out) begin
      out_q <= {converged_i, std_q, mean, worst_q, best_q, cnt_q};
    end
  end

  assign reward_o   = rew_q;
  assign count_o    = cnt_q;
  assign out_data_o = out_q;

endmodule
`default_nettype wire

// ===== src/rsc_ctrl.sv =====
// Sequencer that steps one reward through update, multiply, root and divide phases.
`default_nettype none
module rsc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire rsc_pkg::rsc_stat_t stat_i,
  output rsc_pkg::rsc_cmd_t       cmd_o
);

  rsc_pkg::rsc_state_e state_q, state_d;
  logic [rsc_pkg::STEP_W-1:0] step_q, step_d;
  logic out_valid_q, out_valid_d, out_free, first, ph_end;
  int unsigned ph_len;

  assign out_free = !out_valid_q || out_ready_i;
  assign first    = (step_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsc_pkg::S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    step_d  = step_q;
    ph_len  = 0;
    unique case (state_q)
      rsc_pkg::S_MULP: ph_len = rsc_pkg::MULP_STEPS;
      rsc_pkg::S_MULD: ph_len = rsc_pkg::MULD_STEPS;
      rsc_pkg::S_SQRT: ph_len = rsc_pkg::SQRT_STEPS;
      rsc_pkg::S_DIVS: ph_len = rsc_pkg::DIV_STEPS;
      rsc_pkg::S_DIVM: ph_len = rsc_pkg::DIV_STEPS;
      default:         ph_len = 0;
    endcase
    ph_end = (step_q == rsc_pkg::STEP_W'(ph_len));
    // Step counter: first cycle of a phase loads its unit, the rest iterate it.
    if (ph_len != 0) step_d = ph_end ? '0 : step_q + rsc_pkg::STEP_W'(1);

    unique case (state_q)
      rsc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = rsc_pkg::S_UPD;
        end
      end
      rsc_pkg::S_UPD: begin
        cmd_o.upd = 1'b1;
        step_d    = '0;
        state_d   = rsc_pkg::S_MULP;
      end
      rsc_pkg::S_MULP: begin
        cmd_o.mul_sel    = rsc_pkg::MUL_SEL_P;
        cmd_o.mul_load   = first;
        cmd_o.walk_start = first;
        cmd_o.mul_step   = !first;
        if (ph_end) state_d = rsc_pkg::S_MULD;
      end
      rsc_pkg::S_MULD: begin
        cmd_o.mul_sel  = rsc_pkg::MUL_SEL_D;
        cmd_o.save_p   = first;
        cmd_o.mul_load = first;
        cmd_o.mul_step = !first;
        if (ph_end) state_d = rsc_pkg::S_SQRT;
      end
      rsc_pkg::S_SQRT: begin
        cmd_o.sqrt_load = first;
        cmd_o.sqrt_step = !first;
        if (ph_end) state_d = rsc_pkg::S_DIVS;
      end
      rsc_pkg::S_DIVS: begin
        cmd_o.div_sel  = rsc_pkg::DIV_SEL_STD;
        cmd_o.div_load = first;
        cmd_o.div_step = !first;
        if (ph_end) state_d = rsc_pkg::S_DIVM;
      end
      rsc_pkg::S_DIVM: begin
        cmd_o.div_sel  = rsc_pkg::DIV_SEL_MEAN;
        cmd_o.save_std = first;
        cmd_o.div_load = first;
        cmd_o.div_step = !first;
        if (ph_end) state_d = rsc_pkg::S_FIN;
      end
      rsc_pkg::S_FIN: begin
        if (stat_i.walk_done && out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = rsc_pkg::S_IDLE;
        end
      end
      default: state_d = rsc_pkg::S_IDLE;
    endcase

    out_valid_d = cmd_o.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  assign in_ready_o  = (state_q == rsc_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== src/reward_statistics_convergence_unit.sv =====
// Top level of the reward statistics and convergence unit.
// A result is offered once the serial phases are through: 16-step and 40-step
//   shift-add multiply, 40-step square root and two 41-step divides, each opening
//   with a load of its unit, plus the update and output steps.
// A new reward is taken only once the last result is loaded for output; the window
//   walk starts with the multiply phases, runs alongside the later ones, and is awaited.
// Reset (rst_ni, async, active low) clears count, sums, best/worst, ring pointer
//   and registers at once; the history ring is not cleared and needs no clearing pass.
`default_nettype none
module reward_statistics_convergence_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [rsc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rsc_pkg::THR_W-1:0]     cfg_wdata_i,
  // Reward stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [23:0]                   s_axis_tdata,  // [23:0] reward
  // Result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [15:0] episodes recorded, [39:16] top score, [63:40] low score,
  // [87:64] mean, [110:88] std deviation, [111] converged
  output logic [rsc_pkg::OUT_W-1:0]          m_axis_tdata
);

  rsc_pkg::rsc_cmd_t  cmd;
  rsc_pkg::rsc_stat_t stat;
  logic signed [rsc_pkg::REWARD_W-1:0] reward;
  logic [rsc_pkg::COUNT_W-1:0] count;
  logic converged;

  // Sequencer: one reward in flight, result held in an output register so the
  // next reward can be taken while the previous result waits.
  rsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // All-time statistics, mean and standard deviation.
  rsc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .reward_in_i (s_axis_tdata),
    .converged_i (converged),
    .reward_o    (reward),
    .count_o     (count),
    .out_data_o  (m_axis_tdata)
  );

  // History ring and windowed variance test; also holds the config registers.
  rsc_window u_win (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .reward_i    (reward),
    .count_i     (count),
    .stat_o      (stat),
    .converged_o (converged)
  );

endmodule
`default_nettype wire

// ===== src/rsc_checker.sv =====
// Port-level checks for the reward statistics unit and their binding.
`default_nettype none
module rsc_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [111:0] m_axis_tdata
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One reward at a time: not ready right after a transfer.
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second reward taken while busy");

  // Every result follows at least one recorded reward.
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:0] != 16'd0)
    else $error("result with zero count");

  // Best never below worst once a reward is recorded.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[39:16]) >= $signed(m_axis_tdata[63:40]))
    else $error("best below worst");

endmodule

bind reward_statistics_convergence_unit rsc_checker u_rsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
